// ===== rtl/cau_pkg.sv =====
// Shared types, codes and saturation helper for the complex arithmetic unit.
package cau_pkg;

	// Operation codes carried in s_tuser
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// Width of a pre-clip signed value from add, subtract or multiply
	localparam int VAL_W = 66;
	// Quotient bits kept by the divider (values up to 2^33 - 1)
	localparam int Q_W = 33;
	// Width of the divisor squared magnitude
	localparam int DEN_W = 64;

	localparam logic [31:0] POS_LIM = 32'h7fff_ffff;
	localparam logic [31:0] NEG_LIM = 32'h8000_0000;

	// Result and flags that ride alongside the divider
	typedef struct packed {
		logic [31:0] res_r;
		logic [31:0] res_i;
		logic        sat;
		logic        dz;
		logic        is_div;
		logic        neg_r;
		logic        neg_i;
	} side_t;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} clip_t;

	// Clip a signed value to 32 bits
	function automatic clip_t sat32(input logic signed [VAL_W-1:0] v);
		clip_t r;
		r.sat = 1'b0;
		r.val = v[31:0];
		if (v > $signed({{(VAL_W-32){1'b0}}, POS_LIM})) begin
			r.sat = 1'b1;
			r.val = POS_LIM;
		end else if (v < $signed({{(VAL_W-32){1'b1}}, NEG_LIM})) begin
			r.sat = 1'b1;
			r.val = NEG_LIM;
		end
		return r;
	endfunction

endpackage

// ===== rtl/complex_arithmetic_unit_top.sv =====
// Top level of the complex arithmetic unit: front pipeline, divider, output stage.
//
// Complex add, subtract, multiply and divide on signed Q16.16 operands.
// Slave stream: s_tdata carries a_real, a_imag, b_real, b_imag; s_tuser the
// operation code. A transfer happens when s_tvalid and s_tready are high.
// Master stream: m_tdata carries res_real, res_imag; m_tuser the flags
// saturated and div_zero. Results leave in the order operands arrived.
// Throughput: one transfer per cycle in and out while the receiver keeps m_tready high.
// Every operation passes through three front stages (products,
// combine, finish), one divider overflow stage, 33 quotient stages (one
// restoring step each) and the output register. Non-divide results ride
// through the divider stages unchanged so ordering is kept.
// Each stage holds while its successor is full, so bubbles collapse and a
// receiver stall backs up stage by stage; s_tready drops only when every
// stage holds an item. Nothing is dropped or repeated.
// Reset (arst_n low) clears all valid bits; in-flight items are discarded.
// A divide by zero returns zero with div_zero set; clipped parts set saturated.
module complex_arithmetic_unit_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] a_real, [63:32] a_imag, [95:64] b_real, [127:96] b_imag
	input  logic [127:0] s_tdata,
	// [1:0] req_type
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] res_real, [63:32] res_imag
	output logic [63:0]  m_tdata,
	// [0] saturated, [1] div_zero
	output logic [1:0]   m_tuser
);
	localparam int NW = 64 + FRAC_BITS;

	logic                          f_valid, f_ready;
	logic [NW-1:0]                 f_num_r, f_num_i;
	logic [cau_pkg::DEN_W-1:0]     f_den;
	cau_pkg::side_t                f_side;

	logic                          d_valid, d_ready;
	logic [cau_pkg::Q_W-1:0]       d_q_r, d_q_i;
	logic                          d_ovf_r, d_ovf_i;
	cau_pkg::side_t                d_side;

	cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (s_tuser),
		.ar        (s_tdata[31:0]),
		.ai        (s_tdata[63:32]),
		.br        (s_tdata[95:64]),
		.bi        (s_tdata[127:96]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.num_r     (f_num_r),
		.num_i     (f_num_i),
		.den       (f_den),
		.side      (f_side)
	);

	cau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.num_r     (f_num_r),
		.num_i     (f_num_i),
		.den       (f_den),
		.side_in   (f_side),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.q_r       (d_q_r),
		.q_i       (d_q_i),
		.ovf_r     (d_ovf_r),
		.ovf_i     (d_ovf_i),
		.side_out  (d_side)
	);

	// clip a quotient magnitude with its sign
	function automatic cau_pkg::clip_t qclip(input logic [cau_pkg::Q_W-1:0] q,
	                                         input logic ovf, input logic neg);
		cau_pkg::clip_t r;
		logic [cau_pkg::Q_W-1:0] nq;
		nq    = -q;
		r.sat = 1'b0;
		if (neg) begin
			if (ovf || q > cau_pkg::Q_W'(cau_pkg::NEG_LIM)) begin
				r.sat = 1'b1;
				r.val = cau_pkg::NEG_LIM;
			end else begin
				r.val = nq[31:0];
			end
		end else begin
			if (ovf || q > cau_pkg::Q_W'(cau_pkg::POS_LIM)) begin
				r.sat = 1'b1;
				r.val = cau_pkg::POS_LIM;
			end else begin
				r.val = q[31:0];
			end
		end
		return r;
	endfunction

	// output stage
	logic            v_out_q;
	logic [63:0]     data_q;
	logic [1:0]      user_q;
	cau_pkg::clip_t  qc_r, qc_i;

	assign d_ready = !v_out_q || m_tready;

	always_comb begin
		qc_r = qclip(d_q_r, d_ovf_r, d_side.neg_r);
		qc_i = qclip(d_q_i, d_ovf_i, d_side.neg_i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out_q <= 1'b0;
		else if (d_ready) v_out_q <= d_valid;
	end

	always_ff @(posedge clk) begin
		if (d_ready && d_valid) begin
			if (d_side.is_div && !d_side.dz) begin
				data_q <= {qc_i.val, qc_r.val};
				user_q <= {1'b0, qc_r.sat || qc_i.sat};
			end else begin
				data_q <= {d_side.res_i, d_side.res_r};
				user_q <= {d_side.dz, d_side.sat};
			end
		end
	end

	assign m_tvalid = v_out_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

	// zero divisor gives a zero, unsaturated result
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == 64'd0 && !m_tuser[0])
		else $error("div_zero result not zero");

	// a saturated result has a part at a range limit
	a_sat_lim: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[31:0] == cau_pkg::POS_LIM || m_tdata[31:0] == cau_pkg::NEG_LIM ||
			m_tdata[63:32] == cau_pkg::POS_LIM || m_tdata[63:32] == cau_pkg::NEG_LIM)
		else $error("saturated flag without a limit value");

	// an empty output register means the whole pipe can accept
	a_rdy_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

endmodule

// ===== rtl/cau_front.sv =====
// Front pipeline: operand products, combine, add/sub/mul finish, divide setup.
module cau_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    op,
	input  logic signed [31:0]            ar,
	input  logic signed [31:0]            ai,
	input  logic signed [31:0]            br,
	input  logic signed [31:0]            bi,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [64+FRAC_BITS-1:0]       num_r,
	output logic [64+FRAC_BITS-1:0]       num_i,
	output logic [cau_pkg::DEN_W-1:0]     den,
	output cau_pkg::side_t                side
);
	localparam int NW = 64 + FRAC_BITS;

	// stage 1: products and sums
	logic               v_s1, rdy_s1;
	logic [1:0]         op_s1;
	logic signed [63:0] p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1, p_br2_s1, p_bi2_s1;
	logic signed [32:0] sum_r_s1, sum_i_s1;
	// stage 2: combined numerators and divisor
	logic               v_s2, rdy_s2;
	logic [1:0]         op_s2;
	logic signed [64:0] x_r_s2, x_i_s2;
	logic [63:0]        den_s2;
	logic signed [32:0] sum_r_s2, sum_i_s2;
	// stage 3: finished result or divide operands
	logic               v_s3, rdy_s3;
	logic [NW-1:0]      num_r_s3, num_i_s3;
	logic [63:0]        den_s3;
	cau_pkg::side_t     side_s3;

	assign rdy_s3 = !v_s3 || out_ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// stage 1 datapath
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			op_s1    <= op;
			p_rr_s1  <= 64'(ar) * 64'(br);
			p_ii_s1  <= 64'(ai) * 64'(bi);
			p_ir_s1  <= 64'(ai) * 64'(br);
			p_ri_s1  <= 64'(ar) * 64'(bi);
			p_br2_s1 <= 64'(br) * 64'(br);
			p_bi2_s1 <= 64'(bi) * 64'(bi);
			if (op == cau_pkg::OP_SUB) begin
				sum_r_s1 <= 33'(ar) - 33'(br);
				sum_i_s1 <= 33'(ai) - 33'(bi);
			end else begin
				sum_r_s1 <= 33'(ar) + 33'(br);
				sum_i_s1 <= 33'(ai) + 33'(bi);
			end
		end
	end

	// stage 2 datapath
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			op_s2    <= op_s1;
			sum_r_s2 <= sum_r_s1;
			sum_i_s2 <= sum_i_s1;
			den_s2   <= 64'(p_br2_s1) + 64'(p_bi2_s1);
			if (op_s1 == cau_pkg::OP_DIV) begin
				x_r_s2 <= 65'(p_rr_s1) + 65'(p_ii_s1);
				x_i_s2 <= 65'(p_ir_s1) - 65'(p_ri_s1);
			end else begin
				x_r_s2 <= 65'(p_rr_s1) - 65'(p_ii_s1);
				x_i_s2 <= 65'(p_ir_s1) + 65'(p_ri_s1);
			end
		end
	end

	// stage 3: finish non-divide ops, set up divide
	logic signed [cau_pkg::VAL_W-1:0] val_r, val_i;
	cau_pkg::clip_t                   c_r, c_i;
	logic [63:0]                      mag_r, mag_i;
	logic                             is_div, dz;

	always_comb begin
		is_div = (op_s2 == cau_pkg::OP_DIV);
		dz     = is_div && (den_s2 == '0);
		if (op_s2 == cau_pkg::OP_MUL) begin
			val_r = cau_pkg::VAL_W'(x_r_s2) >>> FRAC_BITS;
			val_i = cau_pkg::VAL_W'(x_i_s2) >>> FRAC_BITS;
		end else begin
			val_r = cau_pkg::VAL_W'(sum_r_s2);
			val_i = cau_pkg::VAL_W'(sum_i_s2);
		end
		c_r   = cau_pkg::sat32(val_r);
		c_i   = cau_pkg::sat32(val_i);
		mag_r = x_r_s2[64] ? 64'(-x_r_s2) : x_r_s2[63:0];
		mag_i = x_i_s2[64] ? 64'(-x_i_s2) : x_i_s2[63:0];
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			num_r_s3       <= NW'(mag_r) << FRAC_BITS;
			num_i_s3       <= NW'(mag_i) << FRAC_BITS;
			den_s3         <= den_s2;
			side_s3.is_div <= is_div;
			side_s3.dz     <= dz;
			side_s3.neg_r  <= x_r_s2[64];
			side_s3.neg_i  <= x_i_s2[64];
			side_s3.res_r  <= is_div ? 32'd0 : c_r.val;
			side_s3.res_i  <= is_div ? 32'd0 : c_i.val;
			side_s3.sat    <= is_div ? 1'b0 : (c_r.sat || c_i.sat);
		end
	end

	assign out_valid = v_s3;
	assign num_r     = num_r_s3;
	assign num_i     = num_i_s3;
	assign den       = den_s3;
	assign side      = side_s3;

endmodule

// ===== rtl/cau_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for both parts.
module cau_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [64+FRAC_BITS-1:0]       num_r,
	input  logic [64+FRAC_BITS-1:0]       num_i,
	input  logic [cau_pkg::DEN_W-1:0]     den,
	input  cau_pkg::side_t                side_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cau_pkg::Q_W-1:0]       q_r,
	output logic [cau_pkg::Q_W-1:0]       q_i,
	output logic                          ovf_r,
	output logic                          ovf_i,
	output cau_pkg::side_t                side_out
);
	localparam int NW = 64 + FRAC_BITS;
	localparam int QW = cau_pkg::Q_W;
	localparam int WW = cau_pkg::DEN_W + QW + 1;
	localparam int WR = (NW > WW) ? NW : WW;
	localparam int NS = QW + 1;

	// stage 0 checks overflow, stages 1..QW each resolve one bit
	logic                        v_q   [NS];
	logic                        rdy   [NS+1];
	logic [WR-1:0]               rem_r_q [NS];
	logic [WR-1:0]               rem_i_q [NS];
	logic [QW-1:0]               qr_q  [NS];
	logic [QW-1:0]               qi_q  [NS];
	logic                        ovr_q [NS];
	logic                        ovi_q [NS];
	logic [cau_pkg::DEN_W-1:0]   den_q [NS];
	cau_pkg::side_t              side_q [NS];

	assign rdy[NS] = out_ready;
	assign in_ready = rdy[0];

	// entry stage: quotient reaches 2^QW or more
	logic [WR-1:0] d_top;
	assign d_top = WR'(den) << QW;
	assign rdy[0] = !v_q[0] || rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q[0] <= 1'b0;
		else if (rdy[0]) v_q[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			rem_r_q[0] <= WR'(num_r);
			rem_i_q[0] <= WR'(num_i);
			ovr_q[0]   <= WR'(num_r) >= d_top;
			ovi_q[0]   <= WR'(num_i) >= d_top;
			qr_q[0]    <= '0;
			qi_q[0]    <= '0;
			den_q[0]   <= den;
			side_q[0]  <= side_in;
		end
	end

	// bit stages
	for (genvar k = 1; k < NS; k++) begin : g_step
		localparam int SH = QW - k;
		logic [WR-1:0] d_sh;
		logic          ge_r, ge_i;
		assign d_sh   = WR'(den_q[k-1]) << SH;
		assign ge_r   = rem_r_q[k-1] >= d_sh;
		assign ge_i   = rem_i_q[k-1] >= d_sh;
		assign rdy[k] = !v_q[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[k] <= 1'b0;
			else if (rdy[k]) v_q[k] <= v_q[k-1];
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_q[k-1]) begin
				rem_r_q[k] <= ge_r ? rem_r_q[k-1] - d_sh : rem_r_q[k-1];
				rem_i_q[k] <= ge_i ? rem_i_q[k-1] - d_sh : rem_i_q[k-1];
				qr_q[k]    <= {qr_q[k-1][QW-2:0], ge_r};
				qi_q[k]    <= {qi_q[k-1][QW-2:0], ge_i};
				ovr_q[k]   <= ovr_q[k-1];
				ovi_q[k]   <= ovi_q[k-1];
				den_q[k]   <= den_q[k-1];
				side_q[k]  <= side_q[k-1];
			end
		end
	end

	assign out_valid = v_q[NS-1];
	assign q_r       = qr_q[NS-1];
	assign q_i       = qi_q[NS-1];
	assign ovf_r     = ovr_q[NS-1];
	assign ovf_i     = ovi_q[NS-1];
	assign side_out  = side_q[NS-1];

endmodule

// ===== verif/complex_arithmetic_unit_top_tb.sv =====
// Self-checking testbench for the complex arithmetic unit stream top level.
//
// The bench drives complex operand pairs with an operation code into the slave stream.
// Each accepted transfer is predicted in fixed point and the expectation is queued
// in order. Every result transfer is compared field by field with the oldest
// expectation. Both streams idle at random: mostly short gaps, a few long ones,
// and some stretches with no idling at all.
module complex_arithmetic_unit_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic        sat;
		logic        dz;
	} cplx_result_t;

	// Holds predicted results in arrival order and checks returned ones
	class cplx_result_book;
		cplx_result_t pending[$];
		int           fails;
		int           op_count[4];
		int           checked;
		int           sat_seen;
		int           dz_seen;

		function new();
			fails = 0;
			checked = 0;
			sat_seen = 0;
			dz_seen = 0;
			foreach (op_count[i]) op_count[i] = 0;
		endfunction

		// Clip a wide signed value to 32 bits, raising the flag on overflow
		function automatic logic [31:0] clip32(input logic signed [67:0] v, inout logic sat);
			if (v > 68'sh0_7fff_ffff) begin
				sat = 1'b1;
				return cau_pkg::POS_LIM;
			end
			if (v < -68'sh0_8000_0000) begin
				sat = 1'b1;
				return cau_pkg::NEG_LIM;
			end
			return v[31:0];
		endfunction

		// Truncated quotient (num * 2^16) / den, magnitude held at 2^33
		function automatic logic signed [67:0] div_part(input logic signed [67:0] num,
				input logic [67:0] den);
			logic        neg;
			logic [67:0] mag;
			logic [99:0] q;
			neg = num < 0;
			mag = neg ? -num : num;
			q = {32'b0, mag} << 16;
			q = q / {32'b0, den};
			if (q > 100'h2_0000_0000) q = 100'h2_0000_0000;
			return neg ? -$signed({1'b0, q[66:0]}) : $signed({1'b0, q[66:0]});
		endfunction

		function automatic cplx_result_t compute(input logic [1:0] op,
				input logic signed [31:0] ar, input logic signed [31:0] ai,
				input logic signed [31:0] br, input logic signed [31:0] bi);
			cplx_result_t     r;
			logic signed [67:0] xr, xi, yr, yi, vr, vi;
			logic [67:0]      den;
			xr = ar; xi = ai; yr = br; yi = bi;
			r.sat = 1'b0;
			r.dz = 1'b0;
			vr = 0;
			vi = 0;
			case (op)
				cau_pkg::OP_ADD: begin
					vr = xr + yr;
					vi = xi + yi;
				end
				cau_pkg::OP_SUB: begin
					vr = xr - yr;
					vi = xi - yi;
				end
				cau_pkg::OP_MUL: begin
					// arithmetic shift rounds toward minus infinity
					vr = (xr * yr - xi * yi) >>> 16;
					vi = (xi * yr + xr * yi) >>> 16;
				end
				default: begin
					den = yr * yr + yi * yi;
					if (den == 0) r.dz = 1'b1;
					else begin
						vr = div_part(xr * yr + xi * yi, den);
						vi = div_part(xi * yr - xr * yi, den);
					end
				end
			endcase
			r.re = clip32(vr, r.sat);
			r.im = clip32(vi, r.sat);
			return r;
		endfunction

		function void note_operands(input logic [1:0] op, input logic [127:0] data);
			pending.push_back(compute(op, data[31:0], data[63:32], data[95:64],
				data[127:96]));
			op_count[op]++;
		endfunction

		function void check_result(input logic [63:0] data, input logic [1:0] flags);
			cplx_result_t e;
			if (pending.size() == 0) begin
				$error("result transfer with nothing expected: data %h flags %b", data, flags);
				fails++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (flags[0]) sat_seen++;
			if (flags[1]) dz_seen++;
			if (data[31:0] !== e.re) begin
				$error("res_real expected %h actual %h", e.re, data[31:0]);
				fails++;
			end
			if (data[63:32] !== e.im) begin
				$error("res_imag expected %h actual %h", e.im, data[63:32]);
				fails++;
			end
			if (flags[0] !== e.sat) begin
				$error("saturated expected %b actual %b", e.sat, flags[0]);
				fails++;
			end
			if (flags[1] !== e.dz) begin
				$error("div_zero expected %b actual %b", e.dz, flags[1]);
				fails++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;

	cplx_result_book book;
	bit              sink_calm;

	complex_arithmetic_unit_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Gap length: mostly zero or short, now and then long
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Operand part: full random, small, extreme or zero
	function automatic logic [31:0] pick_part();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5:       return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
			6:          return 32'h7fff_ffff;
			7:          return 32'h8000_0000;
			8:          return 32'h0;
			default:    return $urandom_range(0, 7) - 3;
		endcase
	endfunction

	// Send one operand transfer, waiting for the handshake
	task automatic send_operands(input logic [1:0] op, input logic [31:0] ar,
			input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi,
			input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser <= op;
		s_tdata <= {bi, br, ai, ar};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		book.note_operands(op, {bi, br, ai, ar});
		@(negedge clk);
	endtask

	// Result checking at the rising edge
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) book.check_result(m_tdata, m_tuser);

	// Receiver readiness, with calm stretches of constant readiness
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_calm) m_tready <= 1'b1;
			else begin
				stall = pick_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
				m_tready <= 1'b1;
			end
		end
	end

	// Run limit
	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [31:0] v[4];
		logic [1:0]  op;
		int          burst;
		book = new();
		sink_calm = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = cau_pkg::OP_ADD;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, each operation, overflow, rounding, zero divisor
		send_operands(cau_pkg::OP_ADD,
			32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff, 0);
		send_operands(cau_pkg::OP_ADD,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
		send_operands(cau_pkg::OP_ADD,
			32'h0001_8000, 32'hfffe_0000, 32'h0000_4000, 32'h0003_0000, 0);
		send_operands(cau_pkg::OP_SUB,
			32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff, 0);
		send_operands(cau_pkg::OP_SUB,
			32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 0);
		send_operands(cau_pkg::OP_SUB,
			32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'h0003_0000, 1);
		send_operands(cau_pkg::OP_MUL,
			32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'hffff_0000, 0);
		send_operands(cau_pkg::OP_MUL,
			32'hffff_ffff, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 0);
		send_operands(cau_pkg::OP_MUL,
			32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 0);
		send_operands(cau_pkg::OP_MUL,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		send_operands(cau_pkg::OP_MUL,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
		send_operands(cau_pkg::OP_MUL,
			32'hfffe_8000, 32'h0000_0003, 32'h0000_0005, 32'hffff_fff9, 2);
		send_operands(cau_pkg::OP_DIV,
			32'h0004_0000, 32'h0002_0000, 32'h0002_0000, 32'h0000_0000, 0);
		send_operands(cau_pkg::OP_DIV,
			32'h1234_5678, 32'h8765_4321, 32'h0000_0000, 32'h0000_0000, 0);
		send_operands(cau_pkg::OP_DIV,
			32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
		send_operands(cau_pkg::OP_DIV,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001, 32'h0000_0000, 0);
		send_operands(cau_pkg::OP_DIV,
			32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff, 0);
		send_operands(cau_pkg::OP_DIV,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		send_operands(cau_pkg::OP_DIV,
			32'hffff_ffff, 32'h0000_0001, 32'h0003_0000, 32'h0000_0000, 0);
		send_operands(cau_pkg::OP_DIV,
			32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0003_0000, 3);
		send_operands(cau_pkg::OP_DIV,
			32'h0000_0001, 32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);

		// Random operands in bursts; some bursts with no idling on either side
		for (int n = 0; n < 1500; n += burst) begin
			burst = $urandom_range(20, 80);
			sink_calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < burst; k++) begin
				op = 2'($urandom_range(0, 3));
				foreach (v[i]) v[i] = pick_part();
				if (op == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0) begin
					v[2] = '0;
					v[3] = '0;
				end
				send_operands(op, v[0], v[1], v[2], v[3], sink_calm ? 0 : pick_gap());
			end
		end
		s_tvalid <= 1'b0;
		sink_calm = 1'b0;

		// Drain, then watch for stray results
		while (book.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("covered %0d add, %0d subtract, %0d multiply, %0d divide operand transfers",
			book.op_count[cau_pkg::OP_ADD], book.op_count[cau_pkg::OP_SUB],
			book.op_count[cau_pkg::OP_MUL], book.op_count[cau_pkg::OP_DIV]);
		$display("checked %0d results, %0d saturated, %0d zero divisor",
			book.checked, book.sat_seen, book.dz_seen);
		if (book.fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
